FILE: rtl/blps_pkg.sv
`default_nettype none

package blps_pkg;

  // Width of the elapsed-time counter.
  localparam int TIME_W = 16;
  // Configured times are 16 bits wide; compares run at the wider of the two.
  localparam int CFG_TIME_W = 16;
  localparam int CMP_W = (TIME_W > CFG_TIME_W) ? TIME_W : CFG_TIME_W;

  localparam int BLINKS_W   = 6;
  localparam int DEBOUNCE_W = 8;
  localparam int STABLE_W   = 8;
  localparam int PROGRESS_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_ALTERNATE = 2'd0,
    MODE_SEQUENCE  = 2'd1,
    MODE_TOGETHER  = 2'd2,
    MODE_OFF       = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_ALT   = 3'd0,
    REG_OFF_ALT  = 3'd1,
    REG_ON_SEQ   = 3'd2,
    REG_OFF_SEQ  = 3'd3,
    REG_BLINKS   = 3'd4,
    REG_ON_TOG   = 3'd5,
    REG_OFF_TOG  = 3'd6,
    REG_DEBOUNCE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] on_time_alternate;
    logic [CFG_TIME_W-1:0] off_time_alternate;
    logic [CFG_TIME_W-1:0] on_time_sequence;
    logic [CFG_TIME_W-1:0] off_time_sequence;
    logic [BLINKS_W-1:0]   sequence_blinks;
    logic [CFG_TIME_W-1:0] on_time_together;
    logic [CFG_TIME_W-1:0] off_time_together;
    logic [DEBOUNCE_W-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic red;
    logic blue;
  } leds_t;

endpackage

`default_nettype wire

FILE: rtl/blps_debounce.sv
`default_nettype none

module blps_debounce (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  step,
  input  wire                                  level,
  input  wire  [blps_pkg::DEBOUNCE_W-1:0]      debounce_ticks,
  output blps_pkg::mode_t                      mode_nxt
);

  logic                          last_r, last_nxt;
  logic [blps_pkg::STABLE_W-1:0] stable_r, stable_nxt;
  logic                          latched_r, latched_nxt;
  blps_pkg::mode_t               mode_r, mode_calc;

  always_comb begin
    last_nxt    = last_r;
    stable_nxt  = stable_r;
    latched_nxt = latched_r;
    mode_calc   = mode_r;
    if (level != last_r) begin
      last_nxt   = level;
      stable_nxt = '0;
    end else if (stable_r != {blps_pkg::STABLE_W{1'b1}}) begin
      stable_nxt = stable_r + 1'b1;
    end
    if (stable_nxt > blps_pkg::STABLE_W'(debounce_ticks)) begin
      if (!level) begin
        if (!latched_r) begin
          latched_nxt = 1'b1;
          mode_calc   = blps_pkg::mode_t'(mode_r + 2'd1);
        end
      end else begin
        latched_nxt = 1'b0;
      end
    end
  end

  assign mode_nxt = mode_calc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= 1'b1;
      stable_r  <= '0;
      latched_r <= 1'b0;
      mode_r    <= blps_pkg::MODE_ALTERNATE;
    end else if (step) begin
      last_r    <= last_nxt;
      stable_r  <= stable_nxt;
      latched_r <= latched_nxt;
      mode_r    <= mode_calc;
    end
  end

  // The mode moves by at most one place per tick.
  a_mode_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (mode_calc == mode_r) || (mode_calc == blps_pkg::mode_t'(mode_r + 2'd1)))
    else $error("mode jumped by more than one");

endmodule

`default_nettype wire

FILE: rtl/blps_pattern.sv
`default_nettype none

module blps_pattern (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  blps_pkg::mode_t     mode,
  input  blps_pkg::cfg_t      cfg,
  output blps_pkg::leds_t     leds_nxt
);

  logic [blps_pkg::TIME_W-1:0]     elapsed_r, elapsed_nxt, elapsed_inc;
  logic                            phase_r, phase_nxt;
  logic [blps_pkg::PROGRESS_W-1:0] progress_r, progress_nxt, progress_inc;
  logic [blps_pkg::PROGRESS_W-1:0] n2, n4;
  logic                            red_r, red_nxt, blue_r, blue_nxt;
  logic [blps_pkg::CFG_TIME_W-1:0] limit;
  logic                            due;

  assign elapsed_inc = (elapsed_r == {blps_pkg::TIME_W{1'b1}}) ? elapsed_r
                                                                : elapsed_r + 1'b1;
  assign n2 = {1'b0, cfg.sequence_blinks, 1'b0};
  assign n4 = {cfg.sequence_blinks, 2'b00};
  assign progress_inc = progress_r + 1'b1;

  always_comb begin
    unique case (mode)
      blps_pkg::MODE_ALTERNATE:
        limit = phase_r ? cfg.off_time_alternate : cfg.on_time_alternate;
      blps_pkg::MODE_SEQUENCE:
        limit = phase_r ? cfg.off_time_sequence : cfg.on_time_sequence;
      blps_pkg::MODE_TOGETHER:
        limit = phase_r ? cfg.off_time_together : cfg.on_time_together;
      default:
        limit = '0;
    endcase
  end

  assign due = blps_pkg::CMP_W'(elapsed_inc) >= blps_pkg::CMP_W'(limit);

  always_comb begin
    elapsed_nxt  = elapsed_inc;
    phase_nxt    = phase_r;
    progress_nxt = progress_r;
    red_nxt      = red_r;
    blue_nxt     = blue_r;
    unique case (mode)
      blps_pkg::MODE_ALTERNATE: begin
        if (due) begin
          elapsed_nxt = '0;
          red_nxt     = !phase_r;
          blue_nxt    = phase_r;
          phase_nxt   = !phase_r;
        end
      end
      blps_pkg::MODE_SEQUENCE: begin
        if (due) begin
          elapsed_nxt = '0;
          if (progress_r < n2) begin
            red_nxt = !phase_r;
          end else if (progress_r < n4) begin
            blue_nxt = !phase_r;
          end
          if (phase_r) begin
            phase_nxt    = 1'b0;
            progress_nxt = (progress_inc >= n4) ? '0 : progress_inc;
          end else begin
            phase_nxt = 1'b1;
          end
        end
      end
      blps_pkg::MODE_TOGETHER: begin
        if (due) begin
          elapsed_nxt = '0;
          red_nxt     = !phase_r;
          blue_nxt    = !phase_r;
          phase_nxt   = !phase_r;
        end
      end
      blps_pkg::MODE_OFF: begin
        // The elapsed time keeps running here and is not restarted.
        red_nxt      = 1'b0;
        blue_nxt     = 1'b0;
        phase_nxt    = 1'b0;
        progress_nxt = '0;
      end
    endcase
  end

  assign leds_nxt.red  = red_nxt;
  assign leds_nxt.blue = blue_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      phase_r    <= 1'b0;
      progress_r <= '0;
      red_r      <= 1'b0;
      blue_r     <= 1'b0;
    end else if (step) begin
      elapsed_r  <= elapsed_nxt;
      phase_r    <= phase_nxt;
      progress_r <= progress_nxt;
      red_r      <= red_nxt;
      blue_r     <= blue_nxt;
    end
  end

  a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && mode == blps_pkg::MODE_OFF) |=> (!phase_r && progress_r == '0 && !red_r && !blue_r))
    else $error("off mode did not clear pattern state");

endmodule

`default_nettype wire

FILE: rtl/button_led_pattern_sequencer.sv
// A beat accepted on the input is held in the input register, then moves to the
// result register once that register is free or emptying, and leaves from there.
// Throughput: one beat per cycle while out_tready is high; the tick's whole update
// is a single pass of counters and compares between input and result registers.
// Reset: synchronous, active low; clears the pattern state and loads the
// default register values, and both channels come out of reset empty.
`default_nettype none

module button_led_pattern_sequencer (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [7:0]                            in_tdata,   // [0] button_level
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [7:0]                            out_tdata,  // [0] red_on, [1] blue_on,
                                                            // [3:2] current_mode
  input  wire                                   cfg_we,
  input  wire  [blps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [blps_pkg::CFG_DATA_W-1:0]       cfg_data
);

  blps_pkg::cfg_t  cfg_r;
  logic            in_valid_r;
  logic            level_r;
  logic            out_valid_r;
  blps_pkg::leds_t out_leds_r;
  blps_pkg::mode_t out_mode_r;
  logic            step;
  blps_pkg::mode_t mode_nxt;
  blps_pkg::leds_t leds_nxt;

  // The input register moves on when the result register is free or emptying.
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time_alternate  <= 16'd250;
      cfg_r.off_time_alternate <= 16'd250;
      cfg_r.on_time_sequence   <= 16'd150;
      cfg_r.off_time_sequence  <= 16'd150;
      cfg_r.sequence_blinks    <= 6'd3;
      cfg_r.on_time_together   <= 16'd100;
      cfg_r.off_time_together  <= 16'd100;
      cfg_r.debounce_ticks     <= 8'd20;
    end else if (cfg_we) begin
      unique case (blps_pkg::reg_idx_t'(cfg_index))
        blps_pkg::REG_ON_ALT:   cfg_r.on_time_alternate  <= cfg_data;
        blps_pkg::REG_OFF_ALT:  cfg_r.off_time_alternate <= cfg_data;
        blps_pkg::REG_ON_SEQ:   cfg_r.on_time_sequence   <= cfg_data;
        blps_pkg::REG_OFF_SEQ:  cfg_r.off_time_sequence  <= cfg_data;
        blps_pkg::REG_BLINKS:   cfg_r.sequence_blinks    <= cfg_data[blps_pkg::BLINKS_W-1:0];
        blps_pkg::REG_ON_TOG:   cfg_r.on_time_together   <= cfg_data;
        blps_pkg::REG_OFF_TOG:  cfg_r.off_time_together  <= cfg_data;
        blps_pkg::REG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_data[blps_pkg::DEBOUNCE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      level_r <= in_tdata[0];
    end
  end

  blps_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .level          (level_r),
    .debounce_ticks (cfg_r.debounce_ticks),
    .mode_nxt       (mode_nxt)
  );

  blps_pattern u_pattern (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .mode     (mode_nxt),
    .cfg      (cfg_r),
    .leds_nxt (leds_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_leds_r <= leds_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_mode_r, out_leds_r.blue, out_leds_r.red};

  a_step_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed beat did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mode_r == blps_pkg::MODE_OFF) |-> (!out_leds_r.red && !out_leds_r.blue))
    else $error("LEDs lit in off mode");

endmodule

`default_nettype wire
